// ===== rtl/core/cgc_pkg.sv =====
// ----------------------------------------------------------------------------
// cgc_pkg: shared types and constants of the coverage colorizer
// Holds the controller state encoding, the command and status bundles that
// pass between controller and datapath, and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package cgc_pkg;

  // Fixed field widths.
  localparam int CH_W    = 8;
  localparam int COLOR_W = 24;
  localparam int DIM_W   = 13;
  localparam int DIM_MAX = 8191;
  localparam int NUM_CH  = 3;

  // The quotient of one gradient channel is below 256, so eight
  // restoring steps resolve it.
  localparam int QUOT_W = 8;
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;
  localparam logic [STEP_W-1:0] STEP_ZERO = 3'd0;

  // Register map.
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;
  localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_START    = 3'd2;
  localparam logic [IDX_W-1:0] REG_END      = 3'd3;
  localparam logic [IDX_W-1:0] REG_GRADIENT = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_LOAD = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              mul;
    logic              div_step;
    logic              load;
    logic [STEP_W-1:0] div_shift;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_dim;
    logic row_end;
    logic gradient;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/coverage_to_rgba_gradient_colorizer.sv =====
// ----------------------------------------------------------------------------
// coverage_to_rgba_gradient_colorizer: glyph coverage to RGBA pixels
// Turns a raster-ordered coverage stream into pixels with a single or a
// vertically graded color, flagging the last pixel of each row and image.
// ----------------------------------------------------------------------------
// Usage: coverage bytes arrive on the in_ channel, one transfer per pixel in
// raster order; each yields one transfer on the out_ channel carrying alpha
// (the coverage), the row color, and row and image end flags. Registers are
// set over the APB port while the stream is idle: width at 0x00, height at
// 0x04, start color at 0x08, end color at 0x0C, gradient enable at 0x10.
// The result is valid in the cycle after acceptance in single-color mode
// and for every pixel of a row whose color is already known. In gradient
// mode the first pixel of each row, and the first after any register write,
// goes through the multiply state for the per-channel multiply, the divide
// state for the restoring divide (one quotient bit per cycle, three channels
// side by side), the load state that clamps and loads the color, and then
// the output state. Within a row, one pixel per cycle while out_ready is high.
// A new pixel is taken in the same cycle that the held result is taken; while
// out_ready is low the result holds and in_ready stays low. With zero width
// or height a pixel is consumed and produces nothing. Reset clears the counters
// and sets width 1, height 1, black colors and single-color mode.
// ----------------------------------------------------------------------------
`default_nettype none

module coverage_to_rgba_gradient_colorizer #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Configuration port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cgc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [cgc_pkg::DATA_W-1:0]  pwdata,
  output logic      [cgc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  // Coverage input.
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cgc_pkg::CH_W-1:0]    in_coverage,
  // Pixel output.
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [cgc_pkg::CH_W-1:0]    out_alpha,
  output logic      [cgc_pkg::CH_W-1:0]    out_red,
  output logic      [cgc_pkg::CH_W-1:0]    out_green,
  output logic      [cgc_pkg::CH_W-1:0]    out_blue,
  output logic                             out_row_end,
  output logic                             out_image_end
);

  logic [cgc_pkg::DIM_W-1:0]   image_width_r;
  logic [cgc_pkg::DIM_W-1:0]   image_height_r;
  logic [cgc_pkg::COLOR_W-1:0] start_color_r;
  logic [cgc_pkg::COLOR_W-1:0] end_color_r;
  logic                        gradient_on_r;

  logic                        cfg_wr;
  logic [cgc_pkg::IDX_W-1:0]   cfg_idx;
  cgc_pkg::dp_cmd_t            cmd;
  cgc_pkg::dp_status_t         status;

  // The register index is the word address; unused indexes are ignored.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[cgc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= cgc_pkg::DIM_W'(1);
      image_height_r <= cgc_pkg::DIM_W'(1);
      start_color_r  <= '0;
      end_color_r    <= '0;
      gradient_on_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        cgc_pkg::REG_WIDTH:    image_width_r  <= pwdata[cgc_pkg::DIM_W-1:0];
        cgc_pkg::REG_HEIGHT:   image_height_r <= pwdata[cgc_pkg::DIM_W-1:0];
        cgc_pkg::REG_START:    start_color_r  <= pwdata[cgc_pkg::COLOR_W-1:0];
        cgc_pkg::REG_END:      end_color_r    <= pwdata[cgc_pkg::COLOR_W-1:0];
        cgc_pkg::REG_GRADIENT: gradient_on_r  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      cgc_pkg::REG_WIDTH:    prdata = cgc_pkg::DATA_W'(image_width_r);
      cgc_pkg::REG_HEIGHT:   prdata = cgc_pkg::DATA_W'(image_height_r);
      cgc_pkg::REG_START:    prdata = cgc_pkg::DATA_W'(start_color_r);
      cgc_pkg::REG_END:      prdata = cgc_pkg::DATA_W'(end_color_r);
      cgc_pkg::REG_GRADIENT: prdata = cgc_pkg::DATA_W'(gradient_on_r);
      default:               prdata = '0;
    endcase
  end

  cgc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_wr    (cfg_wr),
    .status    (status),
    .cmd       (cmd)
  );

  cgc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .start_color  (start_color_r),
    .end_color    (end_color_r),
    .gradient_on  (gradient_on_r),
    .coverage     (in_coverage),
    .alpha        (out_alpha),
    .red          (out_red),
    .green        (out_green),
    .blue         (out_blue),
    .row_end      (out_row_end),
    .image_end    (out_image_end)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cgc_datapath.sv =====
// ----------------------------------------------------------------------------
// cgc_datapath: counters, gradient arithmetic and result registers
// Tracks column and row, forms the row color with one multiply and an
// eight-step shared-time restoring divide per channel, and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cgc_datapath #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cgc_pkg::dp_cmd_t              cmd,
  output cgc_pkg::dp_status_t                status,
  input  wire logic [cgc_pkg::DIM_W-1:0]     image_width,
  input  wire logic [cgc_pkg::DIM_W-1:0]     image_height,
  input  wire logic [cgc_pkg::COLOR_W-1:0]   start_color,
  input  wire logic [cgc_pkg::COLOR_W-1:0]   end_color,
  input  wire logic                          gradient_on,
  input  wire logic [cgc_pkg::CH_W-1:0]      coverage,
  output logic      [cgc_pkg::CH_W-1:0]      alpha,
  output logic      [cgc_pkg::CH_W-1:0]      red,
  output logic      [cgc_pkg::CH_W-1:0]      green,
  output logic      [cgc_pkg::CH_W-1:0]      blue,
  output logic                               row_end,
  output logic                               image_end
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int W_LIM = (MAX_WIDTH < cgc_pkg::DIM_MAX) ? MAX_WIDTH : cgc_pkg::DIM_MAX;
  localparam int H_LIM = (MAX_HEIGHT < cgc_pkg::DIM_MAX) ? MAX_HEIGHT : cgc_pkg::DIM_MAX;
  localparam int CXW   = (CW > cgc_pkg::DIM_W) ? CW : cgc_pkg::DIM_W;
  localparam int RXW   = (RW > cgc_pkg::DIM_W) ? RW : cgc_pkg::DIM_W;
  localparam int MW    = cgc_pkg::CH_W + RW;
  localparam int XW    = (MW > cgc_pkg::DIM_W + cgc_pkg::QUOT_W) ?
                         MW : cgc_pkg::DIM_W + cgc_pkg::QUOT_W;
  localparam int VW    = cgc_pkg::CH_W + 2;

  logic [cgc_pkg::DIM_W-1:0] w_eff;
  logic [cgc_pkg::DIM_W-1:0] h_eff;
  logic [CXW-1:0]            w_last;
  logic [RXW-1:0]            h_last;
  logic                      rend;
  logic                      iend;
  logic [RW-1:0]             r_sel;

  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [RW-1:0]  r_r;
  logic [cgc_pkg::CH_W-1:0]    cov_r;
  logic                        rend_r, iend_r;
  logic [cgc_pkg::COLOR_W-1:0] color_r;
  logic [cgc_pkg::NUM_CH-1:0][cgc_pkg::CH_W-1:0] lane_val;

  assign w_eff = (image_width > cgc_pkg::DIM_W'(W_LIM)) ? cgc_pkg::DIM_W'(W_LIM) : image_width;
  assign h_eff = (image_height > cgc_pkg::DIM_W'(H_LIM)) ?
                 cgc_pkg::DIM_W'(H_LIM) : image_height;

  assign w_last = CXW'(w_eff) - CXW'(1);
  assign h_last = RXW'(h_eff) - RXW'(1);

  // A column or row at or past the last one ends the row or image, which
  // covers geometry shrunk in the middle of an image.
  assign rend  = CXW'(col_r) >= w_last;
  assign iend  = rend && (RXW'(row_r) >= h_last);
  assign r_sel = (RXW'(row_r) < RXW'(h_eff)) ? row_r : RW'(h_last);

  assign status.zero_dim = (w_eff == '0) || (h_eff == '0);
  assign status.row_end  = rend;
  assign status.gradient = gradient_on;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.accept && !status.zero_dim) begin
      if (rend) begin
        col_nxt = '0;
        row_nxt = iend ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  genvar ch;
  generate
    for (ch = 0; ch < cgc_pkg::NUM_CH; ch++) begin : g_lane
      logic [cgc_pkg::CH_W-1:0] s_ch;
      logic [cgc_pkg::CH_W-1:0] e_ch;
      logic [cgc_pkg::CH_W:0]   diff;
      logic [cgc_pkg::CH_W:0]   diff_abs;
      logic [MW-1:0]            prod;
      logic [XW-1:0]            den;
      logic [XW-1:0]            rem_r;
      logic [cgc_pkg::QUOT_W-1:0] q_r;
      logic                     neg_r;
      logic signed [VW-1:0]     val;

      assign s_ch     = start_color[ch*cgc_pkg::CH_W +: cgc_pkg::CH_W];
      assign e_ch     = end_color[ch*cgc_pkg::CH_W +: cgc_pkg::CH_W];
      assign diff     = {1'b0, e_ch} - {1'b0, s_ch};
      assign diff_abs = diff[cgc_pkg::CH_W] ? (~diff + 1'b1) : diff;
      assign prod     = MW'(diff_abs[cgc_pkg::CH_W-1:0]) * MW'(r_r);
      assign den      = XW'(h_eff) << cmd.div_shift;

      // Magnitude division, sign applied after, gives truncation toward zero.
      always_ff @(posedge clk) begin
        if (cmd.mul) begin
          rem_r <= XW'(prod);
          q_r   <= '0;
          neg_r <= diff[cgc_pkg::CH_W];
        end else if (cmd.div_step) begin
          if (rem_r >= den) begin
            rem_r              <= rem_r - den;
            q_r[cmd.div_shift] <= 1'b1;
          end
        end
      end

      assign val = neg_r ? (signed'(VW'(s_ch)) - signed'(VW'(q_r))) :
                           (signed'(VW'(s_ch)) + signed'(VW'(q_r)));

      always_comb begin
        if (val[VW-1]) begin
          lane_val[ch] = '0;
        end else if (val[VW-2]) begin
          lane_val[ch] = '1;
        end else begin
          lane_val[ch] = val[cgc_pkg::CH_W-1:0];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cov_r  <= coverage;
      rend_r <= rend;
      iend_r <= iend;
      r_r    <= r_sel;
      if (!gradient_on) begin
        color_r <= start_color;
      end
    end else if (cmd.load) begin
      color_r <= lane_val;
    end
  end

  assign alpha     = cov_r;
  assign red       = color_r[2*cgc_pkg::CH_W +: cgc_pkg::CH_W];
  assign green     = color_r[cgc_pkg::CH_W +: cgc_pkg::CH_W];
  assign blue      = color_r[0 +: cgc_pkg::CH_W];
  assign row_end   = rend_r;
  assign image_end = iend_r;

endmodule

`default_nettype wire

// ===== rtl/core/cgc_ctrl.sv =====
// ----------------------------------------------------------------------------
// cgc_ctrl: sequencing of the coverage colorizer
// Runs the handshakes, decides when a row color has to be worked out, steps
// the divider and keeps a flag that tells whether the held row color is good.
// ----------------------------------------------------------------------------
`default_nettype none

module cgc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire logic                cfg_wr,
  input  wire cgc_pkg::dp_status_t status,
  output cgc_pkg::dp_cmd_t         cmd
);

  cgc_pkg::state_t state_r, state_nxt, dispatch;
  logic [cgc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic color_ok_r, color_ok_nxt;
  logic accept;

  assign in_ready  = (state_r == cgc_pkg::ST_IDLE) ||
                     ((state_r == cgc_pkg::ST_OUT) && out_ready);
  assign out_valid = (state_r == cgc_pkg::ST_OUT);
  assign accept    = in_valid && in_ready;

  always_comb begin
    if (status.zero_dim) begin
      dispatch = cgc_pkg::ST_IDLE;
    end else if (status.gradient && !color_ok_r) begin
      dispatch = cgc_pkg::ST_MUL;
    end else begin
      dispatch = cgc_pkg::ST_OUT;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      cgc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = dispatch;
        end
      end
      cgc_pkg::ST_MUL: begin
        state_nxt = cgc_pkg::ST_DIV;
        step_nxt  = cgc_pkg::STEP_LAST;
      end
      cgc_pkg::ST_DIV: begin
        if (step_r == cgc_pkg::STEP_ZERO) begin
          state_nxt = cgc_pkg::ST_LOAD;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      cgc_pkg::ST_LOAD: begin
        state_nxt = cgc_pkg::ST_OUT;
      end
      cgc_pkg::ST_OUT: begin
        if (accept) begin
          state_nxt = dispatch;
        end else if (out_ready) begin
          state_nxt = cgc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cgc_pkg::ST_IDLE;
      end
    endcase
  end

  // The held color stays good for the rest of a row in gradient mode; a
  // new row or any register write means it must be worked out again.
  always_comb begin
    color_ok_nxt = color_ok_r;
    if (cfg_wr) begin
      color_ok_nxt = 1'b0;
    end else if (accept && !status.zero_dim) begin
      color_ok_nxt = status.gradient && !status.row_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cgc_pkg::ST_IDLE;
      step_r     <= cgc_pkg::STEP_ZERO;
      color_ok_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      color_ok_r <= color_ok_nxt;
    end
  end

  assign cmd.accept    = accept;
  assign cmd.mul       = (state_r == cgc_pkg::ST_MUL);
  assign cmd.div_step  = (state_r == cgc_pkg::ST_DIV);
  assign cmd.load      = (state_r == cgc_pkg::ST_LOAD);
  assign cmd.div_shift = step_r;

  a_mul_then_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cgc_pkg::ST_MUL |=> state_r == cgc_pkg::ST_DIV && step_r == cgc_pkg::STEP_LAST)
    else $error("divide did not start from the top quotient bit");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cgc_pkg::ST_MUL || state_r == cgc_pkg::ST_DIV || state_r == cgc_pkg::ST_LOAD)
    |-> !cmd.accept)
    else $error("transfer accepted while the row color is being computed");

  a_cfg_clears_cache: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !color_ok_r)
    else $error("row color kept across a register write");

  a_stale_goes_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && status.gradient && !color_ok_r && !status.zero_dim)
    |=> state_r == cgc_pkg::ST_MUL)
    else $error("gradient pixel emitted without a fresh row color");

endmodule

`default_nettype wire

// ===== tb/coverage_to_rgba_gradient_colorizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coverage_to_rgba_gradient_colorizer_tb: self-checking bench of the colorizer
// Streams coverage bytes through the block under several register settings
// and idle patterns, works out each expected RGBA pixel with a local shadow
// of the geometry counters and the gradient arithmetic, and compares every
// pixel transfer field by field in arrival order.
// ----------------------------------------------------------------------------

module coverage_to_rgba_gradient_colorizer_tb;

  localparam int MAX_WIDTH      = 4096;
  localparam int MAX_HEIGHT     = 4096;
  // Settling time after the last pixel came out, long enough to cover any
  // item still in flight, such as one that starts a gradient row.
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLDOFF_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 3000;

  // Register slots past the end of the map; writes there must be ignored.
  localparam logic [cgc_pkg::IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [cgc_pkg::IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [cgc_pkg::CH_W-1:0] alpha;
    logic [cgc_pkg::CH_W-1:0] red;
    logic [cgc_pkg::CH_W-1:0] green;
    logic [cgc_pkg::CH_W-1:0] blue;
    logic                     row_end;
    logic                     image_end;
  } pixel_t;

  // Every input of the block starts from a known value.
  logic                         clk         = 1'b0;
  logic                         rst_n       = 1'b0;
  logic                         psel        = 1'b0;
  logic                         penable     = 1'b0;
  logic                         pwrite      = 1'b0;
  logic [cgc_pkg::ADDR_W-1:0]   paddr       = '0;
  logic [cgc_pkg::DATA_W-1:0]   pwdata      = '0;
  logic                         in_valid    = 1'b0;
  logic [cgc_pkg::CH_W-1:0]     in_coverage = '0;
  logic                         out_ready   = 1'b0;

  logic [cgc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         in_ready;
  logic                         out_valid;
  logic [cgc_pkg::CH_W-1:0]     out_alpha;
  logic [cgc_pkg::CH_W-1:0]     out_red;
  logic [cgc_pkg::CH_W-1:0]     out_green;
  logic [cgc_pkg::CH_W-1:0]     out_blue;
  logic                         out_row_end;
  logic                         out_image_end;

  coverage_to_rgba_gradient_colorizer #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_coverage  (in_coverage),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_alpha    (out_alpha),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_row_end  (out_row_end),
    .out_image_end(out_image_end)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register file, at reset values.
  logic [cgc_pkg::DIM_W-1:0]   cfg_width    = cgc_pkg::DIM_W'(1);
  logic [cgc_pkg::DIM_W-1:0]   cfg_height   = cgc_pkg::DIM_W'(1);
  logic [cgc_pkg::COLOR_W-1:0] cfg_start    = '0;
  logic [cgc_pkg::COLOR_W-1:0] cfg_end      = '0;
  logic                        cfg_gradient = 1'b0;

  // Shadow raster position of the next pixel.
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  // Pixels that have been worked out but not yet seen on the output.
  pixel_t pending_pixels[$];

  int mismatch_count = 0;

  // Idle pattern of the current test, in percent of cycles.
  int idle_pct  = 0;
  int stall_pct = 0;

  // The main thread bumps holdoff_seq; the receiver notices the change and
  // runs its own countdown of stalled cycles.
  int holdoff_seq  = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;

  int quiet_cycles = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // One channel of a gradient row: start + (end - start) * r / h, where the
  // quotient is signed and truncates toward zero, then clamped to a byte.
  function automatic logic [cgc_pkg::CH_W-1:0] blend_channel(
      input logic [cgc_pkg::CH_W-1:0] s,
      input logic [cgc_pkg::CH_W-1:0] e,
      input int unsigned r,
      input int unsigned h);
    longint signed v;
    v = longint'(s) + ((longint'(e) - longint'(s)) * longint'(r)) / longint'(h);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return cgc_pkg::CH_W'(v);
  endfunction

  // Works out the pixel that one accepted coverage byte produces and moves
  // the shadow raster position on. A zero dimension yields no pixel at all.
  task automatic colorize_pixel(input logic [cgc_pkg::CH_W-1:0] cov);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    logic [cgc_pkg::COLOR_W-1:0] color;
    pixel_t px;
    w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    h = (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
    if (w != 0 && h != 0) begin
      if (cfg_gradient) begin
        // A row left past the end by a shrunk height takes the last row's color.
        r = (row_pos < h) ? row_pos : h - 1;
        color = {blend_channel(cfg_start[23:16], cfg_end[23:16], r, h),
                 blend_channel(cfg_start[15:8], cfg_end[15:8], r, h),
                 blend_channel(cfg_start[7:0], cfg_end[7:0], r, h)};
      end else begin
        color = cfg_start;
      end
      px.alpha     = cov;
      px.red       = color[23:16];
      px.green     = color[15:8];
      px.blue      = color[7:0];
      px.row_end   = (col_pos >= w - 1);
      px.image_end = px.row_end && (row_pos >= h - 1);
      pending_pixels.push_back(px);
      if (px.row_end) begin
        col_pos = 0;
        row_pos = px.image_end ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
    end
  endtask

  task automatic apply_register(input logic [cgc_pkg::IDX_W-1:0] idx,
                                input logic [cgc_pkg::DATA_W-1:0] data);
    case (idx)
      cgc_pkg::REG_WIDTH:    cfg_width    = data[cgc_pkg::DIM_W-1:0];
      cgc_pkg::REG_HEIGHT:   cfg_height   = data[cgc_pkg::DIM_W-1:0];
      cgc_pkg::REG_START:    cfg_start    = data[cgc_pkg::COLOR_W-1:0];
      cgc_pkg::REG_END:      cfg_end      = data[cgc_pkg::COLOR_W-1:0];
      cgc_pkg::REG_GRADIENT: cfg_gradient = data[0];
      default: ;
    endcase
  endtask

  function automatic logic [cgc_pkg::DATA_W-1:0] shadow_register(
      input logic [cgc_pkg::IDX_W-1:0] idx);
    case (idx)
      cgc_pkg::REG_WIDTH:    return cgc_pkg::DATA_W'(cfg_width);
      cgc_pkg::REG_HEIGHT:   return cgc_pkg::DATA_W'(cfg_height);
      cgc_pkg::REG_START:    return cgc_pkg::DATA_W'(cfg_start);
      cgc_pkg::REG_END:      return cgc_pkg::DATA_W'(cfg_end);
      cgc_pkg::REG_GRADIENT: return cgc_pkg::DATA_W'(cfg_gradient);
      default:               return '0;
    endcase
  endfunction

  function automatic void report_field(input string name,
                                       input logic [cgc_pkg::DATA_W-1:0] want,
                                       input logic [cgc_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Pixel checker: every pixel transfer is matched against the oldest
  // pending prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected pixel, expected none, actual alpha %0h rgb %0h%0h%0h",
                 $time, out_alpha, out_red, out_green, out_blue);
      end else begin
        want = pending_pixels.pop_front();
        report_field("alpha", cgc_pkg::DATA_W'(want.alpha), cgc_pkg::DATA_W'(out_alpha));
        report_field("red", cgc_pkg::DATA_W'(want.red), cgc_pkg::DATA_W'(out_red));
        report_field("green", cgc_pkg::DATA_W'(want.green), cgc_pkg::DATA_W'(out_green));
        report_field("blue", cgc_pkg::DATA_W'(want.blue), cgc_pkg::DATA_W'(out_blue));
        report_field("row_end", cgc_pkg::DATA_W'(want.row_end),
                     cgc_pkg::DATA_W'(out_row_end));
        report_field("image_end", cgc_pkg::DATA_W'(want.image_end),
                     cgc_pkg::DATA_W'(out_image_end));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off when one is requested.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (holdoff_seq != holdoff_seen) begin
      holdoff_seen <= holdoff_seq;
      holdoff_left <= HOLDOFF_CYCLES;
      out_ready    <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any cycle with a transfer on either stream or the register
  // port counts as progress.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d pixels pending", $time, pending_pixels.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offers one coverage byte, idling first at the current rate, and waits
  // for the transfer. The prediction is made at the accepting edge.
  task automatic send_coverage(input logic [cgc_pkg::CH_W-1:0] cov);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_coverage <= cov;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    colorize_pixel(cov);
  endtask

  // Drops the stream and waits until every predicted pixel has arrived, then
  // lets the block finish any item that makes no pixel.
  task automatic settle_stream();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register access: setup cycle, then access cycle, then back to idle.
  task automatic apb_transfer(input logic is_write, input logic [cgc_pkg::IDX_W-1:0] idx,
                              input logic [cgc_pkg::DATA_W-1:0] wdata,
                              output logic [cgc_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (is_write) apply_register(idx, wdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [cgc_pkg::IDX_W-1:0] idx,
                           input logic [cgc_pkg::DATA_W-1:0] data);
    logic [cgc_pkg::DATA_W-1:0] unused;
    apb_transfer(1'b1, idx, data, unused);
  endtask

  task automatic verify_registers();
    logic [cgc_pkg::DATA_W-1:0] got;
    for (int i = cgc_pkg::REG_WIDTH; i <= cgc_pkg::REG_GRADIENT; i++) begin
      apb_transfer(1'b0, cgc_pkg::IDX_W'(i), '0, got);
      report_field($sformatf("register %0d", i), shadow_register(cgc_pkg::IDX_W'(i)), got);
    end
  endtask

  // Waits for the stream to go quiet and writes the whole register set.
  task automatic configure(input logic [cgc_pkg::DATA_W-1:0] w,
                           input logic [cgc_pkg::DATA_W-1:0] h,
                           input logic [cgc_pkg::DATA_W-1:0] s,
                           input logic [cgc_pkg::DATA_W-1:0] e,
                           input logic [cgc_pkg::DATA_W-1:0] g);
    settle_stream();
    write_reg(cgc_pkg::REG_WIDTH, w);
    write_reg(cgc_pkg::REG_HEIGHT, h);
    write_reg(cgc_pkg::REG_START, s);
    write_reg(cgc_pkg::REG_END, e);
    write_reg(cgc_pkg::REG_GRADIENT, g);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // After reset the image is one pixel, black, single color.
  task automatic test_reset_state();
    verify_registers();
    send_coverage(8'h00);
    send_coverage(8'hFF);
    send_coverage(8'h5A);
  endtask

  task automatic test_single_color();
    configure(3, 1, 32'h00FFFFFF, 32'h00000000, 0);
    send_coverage(8'hFF);
    send_coverage(8'h00);
    send_coverage(8'hA5);
  endtask

  // Red rises and green falls across four rows, so the signed quotient is
  // exercised in both directions; blue stays flat.
  task automatic test_gradient_rows();
    configure(1, 4, 32'h0000FF80, 32'h00FF0080, 1);
    repeat (4) send_coverage(cgc_pkg::CH_W'($urandom));
  endtask

  // A zero width or height swallows pixels without producing anything.
  task automatic test_zero_dimensions();
    configure(0, 1, 32'h00123456, 32'h00654321, 0);
    send_coverage(8'h11);
    send_coverage(8'hEE);
    configure(1, 0, 32'h00123456, 32'h00654321, 1);
    send_coverage(8'h77);
  endtask

  // Dimensions above the maximum saturate, while the register keeps the
  // written value.
  task automatic test_saturated_geometry();
    configure(cgc_pkg::DIM_MAX, 5000, 32'h00000000, 32'h00FFFFFF, 1);
    verify_registers();
    repeat (3) send_coverage(cgc_pkg::CH_W'($urandom));
  endtask

  // The counters survive register writes. Shrinking the width past the
  // current column ends the row at once; shrinking the height past the
  // current row ends the image and clamps the gradient row.
  task automatic test_geometry_shrink();
    settle_stream();
    write_reg(cgc_pkg::REG_WIDTH, 2);
    send_coverage(8'h80);
    settle_stream();
    write_reg(cgc_pkg::REG_HEIGHT, 1);
    send_coverage(8'h01);
    send_coverage(8'hFE);
  endtask

  // Writes past the register map change nothing.
  task automatic test_unmapped_write();
    settle_stream();
    for (int i = REG_UNUSED_LO; i <= REG_UNUSED_HI; i++) write_reg(cgc_pkg::IDX_W'(i), '1);
    verify_registers();
    send_coverage(8'h3C);
  endtask

  // --------------------------------------------------------------------------
  // Flow control tests
  // --------------------------------------------------------------------------

  // The receiver holds off for a long stretch while the sender keeps
  // offering pixels, so the block fills and stops taking input.
  task automatic test_backpressure();
    configure(4, 3, 32'h0020E010, 32'h00D01FF0, 1);
    idle_pct  = 0;
    stall_pct = 0;
    holdoff_seq++;
    repeat (40) send_coverage(cgc_pkg::CH_W'($urandom));
  endtask

  // The sender stops mid-image until every pixel has drained, then resumes.
  task automatic test_drain_pause();
    configure(5, 4, 32'h00FF8000, 32'h000080FF, 1);
    idle_pct  = 0;
    stall_pct = 53;
    repeat (12) send_coverage(cgc_pkg::CH_W'($urandom));
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
    repeat (12) send_coverage(cgc_pkg::CH_W'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Random stream
  // --------------------------------------------------------------------------

  function automatic int unsigned pick_dimension();
    case ($urandom_range(19))
      0:       return $urandom_range(MAX_WIDTH, cgc_pkg::DIM_MAX);
      1:       return cgc_pkg::DIM_MAX;
      2, 3:    return $urandom_range(7, 64);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  // Writes a random register set, with junk above each field, and returns
  // the saturated geometry.
  task automatic random_setting(output int unsigned w, output int unsigned h);
    logic [cgc_pkg::DATA_W-1:0] junk;
    logic [cgc_pkg::COLOR_W-1:0] s;
    logic [cgc_pkg::COLOR_W-1:0] e;
    int unsigned raw_w;
    int unsigned raw_h;
    junk  = $urandom;
    raw_w = pick_dimension();
    raw_h = pick_dimension();
    case ($urandom_range(7))
      0:       begin s = '0; e = '1; end
      1:       begin s = '1; e = '0; end
      default: begin s = cgc_pkg::COLOR_W'($urandom); e = cgc_pkg::COLOR_W'($urandom); end
    endcase
    configure({junk[31:cgc_pkg::DIM_W], cgc_pkg::DIM_W'(raw_w)},
              {junk[cgc_pkg::DIM_W +: 32 - cgc_pkg::DIM_W], cgc_pkg::DIM_W'(raw_h)},
              {junk[7:0], s}, {junk[31:24], e},
              {junk[31:1], ($urandom_range(9) < 6)});
    w = (raw_w > MAX_WIDTH) ? MAX_WIDTH : raw_w;
    h = (raw_h > MAX_HEIGHT) ? MAX_HEIGHT : raw_h;
  endtask

  function automatic logic [cgc_pkg::CH_W-1:0] pick_coverage();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return cgc_pkg::CH_W'($urandom);
    endcase
  endfunction

  // Four idle patterns, each with a few register settings. Most settings get
  // whole images; about one in ten gets a short stub that leaves the raster
  // position mid-image for the next setting.
  task automatic test_random_stream();
    int unsigned w;
    int unsigned h;
    int unsigned n;
    for (int stage = 0; stage < 4; stage++) begin
      case (stage)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 53; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      for (int s = 0; s < 4; s++) begin
        random_setting(w, h);
        if ($urandom_range(9) == 0) begin
          n = $urandom_range(1, 15);
        end else if (w * h <= 36) begin
          n = w * h;
          while (n < 20) n += w * h;
        end else begin
          n = $urandom_range(20, 36);
        end
        repeat (n) send_coverage(pick_coverage());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_single_color();
    test_gradient_rows();
    test_zero_dimensions();
    test_saturated_geometry();
    test_geometry_shrink();
    test_unmapped_write();
    test_backpressure();
    test_drain_pause();
    test_random_stream();

    settle_stream();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
